// File: rtl/ntpd_pkg.sv
// Shared types, constants and table functions for the NTP seconds to local date block.
package ntpd_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAYS,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_MONTH,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_DAYS,
    OP_DIV_HOUR,
    OP_DIV_MIN,
    OP_YEAR,
    OP_MONTH,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic out_free;
  } status_t;

  localparam int unsigned ZONE_COUNT = 50;
  localparam logic [5:0]  ZONE_RESET = 6'd39;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;

  localparam logic [3:0] DAY_STEPS  = 4'd1;
  localparam logic [3:0] HOUR_STEPS = 4'd1;
  localparam logic [3:0] MIN_STEPS  = 4'd1;

  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam int ZONE_OFFSET [ZONE_COUNT] = '{
    -43200, -39600, -36000, -34200, -32400, -28800, -28800, -25200,
    -25200, -21600, -21600, -18000, -18000, -18000, -16200, -14400,
    -14400, -12600, -10800,  -7200,  -3600,      0,      0,   3600,
      3600,   3600,   7200,   7200,  10800,  10800,  12600,  14400,
     16200,  18000,  19800,  20700,  21600,  23400,  25200,  28800,
     32400,  34200,  36000,  37800,  39600,  41400,  43200,  45900,
     46800,  50400
  };

  function automatic logic [31:0] zone_offset(input logic [5:0] idx);
    logic [31:0] off;
    off = '0;
    if (32'(idx) < ZONE_COUNT) begin
      off = 32'(ZONE_OFFSET[idx]);
    end
    return off;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    case (m) inside
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/ntpd_ctrl.sv
// Sequencer for the date conversion: divide steps, year loop, month loop, result hand-off.
module ntpd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ntpd_pkg::status_t status_i,
  output ntpd_pkg::cmd_t    cmd_o
);
  import ntpd_pkg::*;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       last;

  assign last = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q - 4'd1;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = DAY_STEPS;
        if (in_valid_i) state_d = S_DAYS;
      end
      S_DAYS: begin
        if (last) begin
          state_d = S_HOUR;
          cnt_d   = HOUR_STEPS;
        end
      end
      S_HOUR: begin
        if (last) begin
          state_d = S_MIN;
          cnt_d   = MIN_STEPS;
        end
      end
      S_MIN: begin
        if (last) state_d = S_YEAR;
      end
      S_YEAR: begin
        if (status_i.year_done) state_d = S_MONTH;
      end
      S_MONTH: begin
        if (status_i.month_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.last = last;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_DAYS:  cmd_o.op = OP_DIV_DAYS;
      S_HOUR:  cmd_o.op = OP_DIV_HOUR;
      S_MIN:   cmd_o.op = OP_DIV_MIN;
      S_YEAR: begin
        if (!status_i.year_done) cmd_o.op = OP_YEAR;
      end
      S_MONTH: begin
        if (!status_i.month_done) cmd_o.op = OP_MONTH;
      end
      S_FINISH: begin
        if (status_i.out_free) cmd_o.op = OP_OUT;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/ntpd_dp.sv
// Datapath: zone register, reciprocal-multiply divide steps, year and month counters, result register.
module ntpd_dp #(
  parameter int EPOCH_YEAR = 1900
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  input  logic [31:0]       ntp_seconds_i,
  input  ntpd_pkg::cmd_t    cmd_i,
  output ntpd_pkg::status_t status_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [10:0]       year_o,
  output logic [3:0]        month_o,
  output logic [4:0]        day_o,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o
);
  import ntpd_pkg::*;

  localparam logic [10:0] YEAR_INIT = 11'(EPOCH_YEAR);
  localparam logic [1:0]  Y4_INIT   = 2'(EPOCH_YEAR % 4);
  localparam logic [6:0]  Y100_INIT = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0]  Y400_INIT = 9'(EPOCH_YEAR % 400);
  localparam logic [6:0]  Y100_LAST = 7'd99;
  localparam logic [8:0]  Y400_LAST = 9'd399;

  logic [5:0]  zone_q;
  logic [31:0] rem_q, rem_d;
  logic [15:0] days_q, days_d;
  logic [10:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [1:0]  y4_q, y4_d;
  logic [6:0]  y100_q, y100_d;
  logic [8:0]  y400_q, y400_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic        out_valid_q;

  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [31:0] sec_left;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  assign day_prod  = 51'(rem_q[31:7]) * 51'(DAY_RECIP);
  assign hour_prod = 27'(rem_q[16:4]) * 27'(HOUR_RECIP);
  assign min_prod  = 21'(rem_q[11:2]) * 21'(MIN_RECIP);
  assign sec_left  = rem_q - 32'(minute_q) * SECS_PER_MIN;

  assign leap = (y400_q == '0) || ((y100_q != '0) && (y4_q == '0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_length(month_q, leap);

  assign status_o.year_done  = (days_q < 16'(ylen));
  assign status_o.month_done = (days_q < 16'(mlen)) || (month_q >= MONTH_DEC);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q      <= ZONE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) zone_q <= cfg_wdata_i;
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    rem_d    = rem_q;
    days_d   = days_q;
    year_d   = year_q;
    month_d  = month_q;
    y4_d     = y4_q;
    y100_d   = y100_q;
    y400_d   = y400_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    unique case (cmd_i.op)
      OP_LOAD: begin
        rem_d   = ntp_seconds_i + zone_offset(zone_q);
        year_d  = YEAR_INIT;
        month_d = 4'd1;
        y4_d    = Y4_INIT;
        y100_d  = Y100_INIT;
        y400_d  = Y400_INIT;
      end
      OP_DIV_DAYS: begin
        if (cmd_i.last) begin
          rem_d = rem_q - 32'(days_q) * SECS_PER_DAY;
        end else begin
          days_d = day_prod[50:35];
        end
      end
      OP_DIV_HOUR: begin
        if (cmd_i.last) begin
          rem_d = rem_q - 32'(hour_q) * SECS_PER_HOUR;
        end else begin
          hour_d = hour_prod[25:21];
        end
      end
      OP_DIV_MIN: begin
        if (cmd_i.last) begin
          second_d = sec_left[5:0];
        end else begin
          minute_d = min_prod[19:14];
        end
      end
      OP_YEAR: begin
        days_d = days_q - 16'(ylen);
        year_d = year_q + 11'd1;
        y4_d   = y4_q + 2'd1;
        y100_d = (y100_q == Y100_LAST) ? '0 : y100_q + 7'd1;
        y400_d = (y400_q == Y400_LAST) ? '0 : y400_q + 9'd1;
      end
      OP_MONTH: begin
        days_d  = days_q - 16'(mlen);
        month_d = month_q + 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    days_q   <= days_d;
    year_q   <= year_d;
    month_q  <= month_d;
    y4_q     <= y4_d;
    y100_q   <= y100_d;
    y400_q   <= y400_d;
    hour_q   <= hour_d;
    minute_q <= minute_d;
    second_q <= second_d;
    if (cmd_i.op == OP_OUT) begin
      year_o   <= year_q;
      month_o  <= month_q;
      day_o    <= days_q[4:0] + 5'd1;
      hour_o   <= hour_q;
      minute_o <= minute_q;
      second_o <= second_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_OUT) |=> out_valid_q)
    else $error("result register not valid after load");

  a_year_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_YEAR) |-> (days_q >= 16'(ylen)))
    else $error("year step would underflow the day count");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (month_o >= 4'd1 && month_o <= MONTH_DEC && day_o != '0))
    else $error("month or day out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (hour_o < 5'd24 && minute_o < 6'd60 && second_o < 6'd60))
    else $error("time of day out of range");

endmodule

// File: rtl/ntp_seconds_to_local_date.sv
// Top level: NTP seconds count to local calendar date and time of day.
//
// Input channel: ntp_seconds_i with in_valid_i / in_stall_o. A transaction is
// taken when valid is high and stall is low; stall is low only while the
// sequencer is idle, so one transaction is in work at a time.
// Output channel: year/month/day/hour/minute/second with out_valid_o /
// out_stall_i. The result sits in an output register, so a new input
// transaction can be taken while the previous result waits for the receiver.
// Sequence: the accepting edge loads the zone-adjusted count; then the day,
// hour and minute splits (each a reciprocal multiply, then the remainder),
// the year loop (one year length taken off per elapsed year, then a closing
// test), the month loop (one month length per elapsed month, ending at
// December at the latest), and the hand-off into the output register.
// The year loop dominates the conversion time.
// A new transaction is taken only once the previous result has been handed
// to the output register, and that hand-off waits while it is not free.
// Configuration: cfg_we_i writes cfg_wdata_i into the zone index; write only
// while idle. Reset sets the zone index to UTC+8 (index 39) and empties the
// output register. If the receiver stalls, the finished result holds and the
// sequencer waits in its last step until the output register frees up.
module ntp_seconds_to_local_date #(
  parameter int EPOCH_YEAR = 1900
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] ntp_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);
  import ntpd_pkg::*;

  cmd_t    cmd;
  status_t status;

  ntpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ntpd_dp #(
    .EPOCH_YEAR (EPOCH_YEAR)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .ntp_seconds_i (ntp_seconds_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .year_o        (year_o),
    .month_o       (month_o),
    .day_o         (day_o),
    .hour_o        (hour_o),
    .minute_o      (minute_o),
    .second_o      (second_o)
  );

endmodule
